FILE: design/cbl_pkg.sv
// Shared constants, types and helper functions for the clipped RGB rectangle blit.
package cbl_pkg;

  localparam int ADDR_BITS  = 26;
  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int CNT_W      = 12;
  localparam int STRIDE_W   = 14;
  localparam int OFF_W      = 14;
  localparam int BPP        = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_LINE_STRIDE  = 3'd2,
    REG_RECT_X       = 3'd3,
    REG_RECT_Y       = 3'd4,
    REG_RECT_WIDTH   = 3'd5,
    REG_RECT_HEIGHT  = 3'd6
  } cfg_reg_t;

  // Geometry derived from the configuration registers, held in flops.
  typedef struct packed {
    logic [DIM_W-1:0]     width;
    logic [DIM_W-1:0]     height;
    logic [DIM_W-1:0]     vis_x;
    logic [DIM_W-1:0]     vis_y;
    logic [STRIDE_W-1:0]  stride;
    logic [ADDR_BITS-1:0] start_base;
  } blit_geom_t;

  // A size of zero counts as one, and sizes above MAX_DIM are capped.
  function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Number of pixels of a span that lie before the clip edge.
  function automatic logic [DIM_W-1:0] visible(input logic [DIM_W-1:0] origin,
                                               input logic [DIM_W-1:0] size,
                                               input logic [DIM_W-1:0] edge_pos);
    logic [DIM_W-1:0] room;
    logic [DIM_W-1:0] r;
    room = edge_pos - origin;
    if (origin >= edge_pos) begin
      r = '0;
    end else if (size < room) begin
      r = size;
    end else begin
      r = room;
    end
    return r;
  endfunction

endpackage

FILE: design/cbl_if.sv
// Stream interfaces for source pixels and frame buffer writes.
interface cbl_pix_if;
  import cbl_pkg::*;
  logic  valid;
  logic  ready;
  byte_t src_red;
  byte_t src_green;
  byte_t src_blue;
  modport source (output valid, output src_red, output src_green, output src_blue,
                  input ready);
  modport sink (input valid, input src_red, input src_green, input src_blue,
                output ready);
endinterface

interface cbl_wr_if;
  import cbl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] byte_address;
  byte_t                out_red;
  byte_t                out_green;
  byte_t                out_blue;
  logic                 blit_last;
  modport source (output valid, output byte_address, output out_red, output out_green,
                  output out_blue, output blit_last, input ready);
  modport sink (input valid, input byte_address, input out_red, input out_green,
                input out_blue, input blit_last, output ready);
endinterface

FILE: design/cbl_cfg.sv
// Configuration registers and the registered blit geometry derived from them.
module cbl_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cbl_pkg::blit_geom_t           geom,
  output logic                          hold
);
  import cbl_pkg::*;

  logic [DIM_W-1:0]     frame_width_r, frame_height_r;
  logic [STRIDE_W-1:0]  line_stride_r;
  logic [CNT_W-1:0]     rect_x_r, rect_y_r;
  logic [DIM_W-1:0]     rect_width_r, rect_height_r;
  logic                 hold_r;
  blit_geom_t           geom_r, geom_nxt;
  logic [ADDR_BITS-1:0] y_prod;
  logic [OFF_W-1:0]     x_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_W'(1920);
      frame_height_r <= DIM_W'(1080);
      line_stride_r  <= STRIDE_W'(5760);
      rect_x_r       <= '0;
      rect_y_r       <= '0;
      rect_width_r   <= DIM_W'(1);
      rect_height_r  <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[DIM_W-1:0];
        REG_LINE_STRIDE:  line_stride_r  <= cfg_wdata[STRIDE_W-1:0];
        REG_RECT_X:       rect_x_r       <= cfg_wdata[CNT_W-1:0];
        REG_RECT_Y:       rect_y_r       <= cfg_wdata[CNT_W-1:0];
        REG_RECT_WIDTH:   rect_width_r   <= cfg_wdata[DIM_W-1:0];
        REG_RECT_HEIGHT:  rect_height_r  <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // The derived geometry is registered from the configuration registers; hold covers the gap while it reloads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b1;
    end else begin
      hold_r <= cfg_we;
    end
  end

  assign y_prod = ADDR_BITS'(rect_y_r * line_stride_r);
  assign x_off  = OFF_W'({rect_x_r, 1'b0}) + OFF_W'(rect_x_r);

  always_comb begin
    geom_nxt.width      = limit_dim(rect_width_r);
    geom_nxt.height     = limit_dim(rect_height_r);
    geom_nxt.vis_x      = visible(DIM_W'(rect_x_r), geom_nxt.width, frame_width_r);
    geom_nxt.vis_y      = visible(DIM_W'(rect_y_r), geom_nxt.height, frame_height_r);
    geom_nxt.stride     = line_stride_r;
    geom_nxt.start_base = y_prod + ADDR_BITS'(x_off);
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom = geom_r;
  assign hold = hold_r;

endmodule

FILE: design/clipped_rgb_rect_blit_core.sv
// Top level of the clipped RGB rectangle blit: pixel stream in, frame buffer writes out.
//
// Source pixels arrive in row order, rect_width pixels per row for rect_height
// rows, and the block takes one per clock. Each pixel that falls inside the
// frame after clipping at the right and bottom edges leaves as one write item
// in the next cycle, carrying the byte address of its red byte (row base plus
// three times the column) and its RGB bytes; blit_last marks the final
// visible pixel of the rectangle. Clipped pixels are consumed without a write.
// The row base is loaded with rect_y * line_stride + rect_x * 3 at the first
// pixel of each blit, so rect_x and rect_y take effect at the next blit start,
// and it steps by line_stride at each row change. The counters rewind after
// the last row on their own. The geometry behind clipping and the start
// address is kept in a register stage fed by the configuration registers:
// in_pix.ready is low in the cycle after reset and in the cycle after each
// configuration write while that stage reloads. Otherwise one item is taken
// every clock as long as the write side keeps up; the only path between the
// sides is the output register, whose ready joins the input ready.
module clipped_rgb_rect_blit_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  cbl_pix_if.sink                       in_pix,
  cbl_wr_if.source                      out_wr
);
  import cbl_pkg::*;

  blit_geom_t           geom;
  logic                 cfg_hold;

  logic [CNT_W-1:0]     col_count_r, col_count_nxt;
  logic [CNT_W-1:0]     row_count_r, row_count_nxt;
  logic [OFF_W-1:0]     col_off_r, col_off_nxt;
  logic [ADDR_BITS-1:0] row_base_r, row_base_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_BITS-1:0] out_addr_r;
  byte_t                out_red_r, out_green_r, out_blue_r;
  logic                 out_last_r;

  logic                 accept;
  logic                 first_px;
  logic [ADDR_BITS-1:0] eff_base;
  logic [DIM_W-1:0]     col_p1, row_p1;
  logic                 px_visible;
  logic                 px_last;
  logic                 col_wrap, row_wrap;
  logic [ADDR_BITS-1:0] px_addr;

  cbl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .hold      (cfg_hold)
  );

  assign in_pix.ready = (!out_valid_r || out_wr.ready) && !cfg_hold;
  assign accept       = in_pix.valid && in_pix.ready;

  // The first pixel of a blit uses the freshly computed start address.
  assign first_px   = (col_count_r == '0) && (row_count_r == '0);
  assign eff_base   = first_px ? geom.start_base : row_base_r;
  assign col_p1     = DIM_W'(col_count_r) + DIM_W'(1);
  assign row_p1     = DIM_W'(row_count_r) + DIM_W'(1);
  assign px_visible = (DIM_W'(col_count_r) < geom.vis_x) &&
                      (DIM_W'(row_count_r) < geom.vis_y);
  assign px_last    = (row_p1 == geom.vis_y) && (col_p1 == geom.vis_x);
  assign px_addr    = eff_base + ADDR_BITS'(col_off_r);
  assign col_wrap   = col_p1 >= geom.width;
  assign row_wrap   = row_p1 >= geom.height;

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    col_off_nxt   = col_off_r;
    row_base_nxt  = row_base_r;
    if (accept) begin
      row_base_nxt = eff_base;
      if (col_wrap) begin
        col_count_nxt = '0;
        col_off_nxt   = '0;
        if (row_wrap) begin
          row_count_nxt = '0;
        end else begin
          row_count_nxt = row_p1[CNT_W-1:0];
          row_base_nxt  = eff_base + ADDR_BITS'(geom.stride);
        end
      end else begin
        col_count_nxt = col_p1[CNT_W-1:0];
        col_off_nxt   = col_off_r + OFF_W'(BPP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      col_off_r   <= '0;
      row_base_r  <= '0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      col_off_r   <= col_off_nxt;
      row_base_r  <= row_base_nxt;
    end
  end

  // Output register: a new item may load in the same cycle the old one leaves.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = px_visible;
    end else if (out_wr.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && px_visible) begin
      out_addr_r  <= px_addr;
      out_red_r   <= in_pix.src_red;
      out_green_r <= in_pix.src_green;
      out_blue_r  <= in_pix.src_blue;
      out_last_r  <= px_last;
    end
  end

  assign out_wr.valid        = out_valid_r;
  assign out_wr.byte_address = out_addr_r;
  assign out_wr.out_red      = out_red_r;
  assign out_wr.out_green    = out_green_r;
  assign out_wr.out_blue     = out_blue_r;
  assign out_wr.blit_last    = out_last_r;

  // The column byte offset always tracks three times the column counter.
  assert property (@(posedge clk) disable iff (!rst_n)
    col_off_r == (OFF_W'({col_count_r, 1'b0}) + OFF_W'(col_count_r)))
    else $error("column offset out of step with column counter");

  // No pixel is taken while the derived geometry reloads after a write.
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !(in_pix.valid && in_pix.ready))
    else $error("pixel accepted before geometry reload");

  // A write item only appears as the result of an accepted pixel.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept))
    else $error("write item without an accepted pixel");

endmodule
